/* design/lztd_pkg.sv */
package lztd_pkg;

	localparam int HISTORY_SIZE_DEF = 4096;

	localparam logic [7:0] MATCH_TAG = 8'hFF;

	typedef enum logic [2:0] {
		PH_TAG,
		PH_LIT,
		PH_OFF_LO,
		PH_OFF_HI,
		PH_LEN
	} phase_t;

	typedef enum logic {
		ST_IDLE,
		ST_COPY
	} fsm_t;

	typedef struct packed {
		logic        halted;
		logic        last;
		logic [2:0]  count;
		logic [31:0] data;
	} res_t;

endpackage

/* design/lz77_token_decompressor.sv */
// Expands an LZ77 token stream arriving one compressed byte per request. Tag, offset, length
// and literal bytes are taken at one per cycle while the queue has room; a literal yields
// one result of one byte. After a length byte the input is held while the copy runs at one
// byte per cycle unless the queue is full, through the single read port of the history
// memory. The memory holds HISTORY_SIZE bytes, reads synchronously and has a bypass for
// offset one. A stalled output stretches the hold. Copied bytes leave packed up to four to
// a result. A two-entry result queue decouples the output side. The history memory has no
// clearing pass: offsets are checked against the bytes produced in the current chunk.
module lz77_token_decompressor
	import lztd_pkg::*;
#(
	parameter int HISTORY_SIZE = HISTORY_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tlast,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata,   // [31:0] out_data, [34:32] out_count, [39:35] zero
	output logic        m_tlast,
	output logic [0:0]  m_tuser    // [0] out_halted
);

	localparam int AW = $clog2(HISTORY_SIZE);
	localparam logic [AW-1:0] LAST_IDX = AW'(HISTORY_SIZE - 1);
	localparam logic [AW+1:0] HS_W = (AW+2)'(HISTORY_SIZE);
	localparam logic [16:0] HS_17 = 17'(HISTORY_SIZE);

	logic [7:0] hist_mem [HISTORY_SIZE];

	fsm_t        st_q, st_d;
	phase_t      ph_q, ph_d;
	logic [31:0] limit_q;
	logic [AW-1:0] wp_q, wp_inc;
	logic [31:0] produced_q;
	logic [7:0]  lit_q, lit_d;
	logic [15:0] off_q, off_d;
	logic        halted_q, halt_d;
	logic        last_q;
	logic [7:0]  rem_q;
	logic [AW-1:0] src_q, src_inc, src0;
	logic [AW+1:0] src_sum;
	logic [7:0]  wbyte_q;
	logic [31:0] pack_q, pack_next;
	logic [1:0]  pack_cnt_q;

	logic        rd_v_s1, fin_s1, fwd_s1;
	logic [7:0]  rd_s1;

	res_t        fifo_q [2];
	logic        fifo_wr_q, fifo_rd_q;
	logic [1:0]  fifo_cnt_q;

	logic        acc, active, lit_wr, start_copy, bad_off;
	logic [31:0] room;
	logic [7:0]  len_c, cbyte;
	logic        adv, iss, need_push, push, pop, acc_push, chunk_clr;
	logic        mem_we;
	logic [7:0]  mem_wd;
	res_t        push_ent;

	assign acc = s_tvalid && s_tready;
	assign pop = m_tvalid && m_tready;

	assign wp_inc  = (wp_q == LAST_IDX) ? '0 : wp_q + 1'b1;
	assign src_inc = (src_q == LAST_IDX) ? '0 : src_q + 1'b1;
	assign src_sum = {2'b00, wp_q} + HS_W - (AW+2)'(off_q);
	assign src0    = (src_sum >= HS_W) ? AW'(src_sum - HS_W) : src_sum[AW-1:0];

	assign room    = limit_q - produced_q;
	assign bad_off = (off_q == 16'h0) || ({16'h0, off_q} > produced_q) ||
			({1'b0, off_q} > HS_17);

	always_comb begin
		active     = !halted_q && (produced_q < limit_q);
		ph_d       = ph_q;
		halt_d     = halted_q;
		off_d      = off_q;
		lit_d      = lit_q;
		lit_wr     = 1'b0;
		start_copy = 1'b0;
		len_c      = (room < {24'h0, s_tdata}) ? room[7:0] : s_tdata;
		if (active) begin
			case (ph_q)
				PH_LIT: begin
					lit_wr = 1'b1;
					lit_d  = (lit_q != 8'h0) ? lit_q - 8'h1 : 8'h0;
					if (lit_d == 8'h0) ph_d = PH_TAG;
				end
				PH_OFF_LO: begin
					off_d = {8'h0, s_tdata};
					if (s_tlast) halt_d = 1'b1;
					else ph_d = PH_OFF_HI;
				end
				PH_OFF_HI: begin
					off_d = {s_tdata, off_q[7:0]};
					if (s_tlast) halt_d = 1'b1;
					else ph_d = PH_LEN;
				end
				PH_LEN: begin
					ph_d = PH_TAG;
					if (bad_off) halt_d = 1'b1;
					else if (len_c != 8'h0) start_copy = 1'b1;
				end
				default: begin
					if (s_tdata == MATCH_TAG) begin
						if (s_tlast) halt_d = 1'b1;
						else ph_d = PH_OFF_LO;
					end else if (s_tdata != 8'h0) begin
						lit_d = s_tdata;
						ph_d  = PH_LIT;
					end else begin
						ph_d = PH_TAG;
					end
				end
			endcase
		end
	end

	// copy datapath
	assign need_push = (pack_cnt_q == 2'd3) || fin_s1;
	assign adv       = rd_v_s1 && (!need_push || (fifo_cnt_q != 2'd2));
	assign iss       = (st_q == ST_COPY) && (rem_q != 8'h0) && (!rd_v_s1 || adv);
	assign cbyte     = fwd_s1 ? wbyte_q : rd_s1;

	always_comb begin
		case (pack_cnt_q)
			2'd0:    pack_next = {24'h0, cbyte};
			2'd1:    pack_next = {16'h0, cbyte, pack_q[7:0]};
			2'd2:    pack_next = {8'h0, cbyte, pack_q[15:0]};
			default: pack_next = {cbyte, pack_q[23:0]};
		endcase
	end

	assign acc_push  = acc && (lit_wr || (s_tlast && !start_copy));
	assign push      = acc_push || (adv && need_push);
	assign chunk_clr = (acc && s_tlast && !start_copy) || (adv && fin_s1 && last_q);
	assign mem_we    = (acc && lit_wr) || adv;
	assign mem_wd    = adv ? cbyte : s_tdata;

	always_comb begin
		if (acc_push) begin
			push_ent.data   = lit_wr ? {24'h0, s_tdata} : 32'h0;
			push_ent.count  = lit_wr ? 3'd1 : 3'd0;
			push_ent.last   = s_tlast;
			push_ent.halted = halt_d;
		end else begin
			push_ent.data   = pack_next;
			push_ent.count  = {1'b0, pack_cnt_q} + 3'd1;
			push_ent.last   = last_q && fin_s1;
			push_ent.halted = 1'b0;
		end
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE: if (acc && start_copy) st_d = ST_COPY;
			ST_COPY: if (adv && fin_s1) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = (st_q == ST_IDLE) && (fifo_cnt_q != 2'd2);
		m_tvalid = (fifo_cnt_q != 2'd0);
		m_tdata  = {5'h0, fifo_q[fifo_rd_q].count, fifo_q[fifo_rd_q].data};
		m_tlast  = fifo_q[fifo_rd_q].last;
		m_tuser  = fifo_q[fifo_rd_q].halted;
	end

	always_ff @(posedge clk) begin
		if (mem_we) hist_mem[wp_q] <= mem_wd;
		if (iss) rd_s1 <= hist_mem[src_q];
	end

	always_ff @(posedge clk) begin
		if (mem_we) wbyte_q <= mem_wd;
		if (push) fifo_q[fifo_wr_q] <= push_ent;
		if (iss) begin
			fin_s1 <= (rem_q == 8'h1);
			fwd_s1 <= rd_v_s1 && (off_q == 16'h1);
		end
		if (acc && start_copy) begin
			src_q  <= src0;
			last_q <= s_tlast;
		end else if (iss) begin
			src_q <= src_inc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= ST_IDLE;
			ph_q       <= PH_TAG;
			limit_q    <= 32'h0;
			wp_q       <= '0;
			produced_q <= 32'h0;
			lit_q      <= 8'h0;
			off_q      <= 16'h0;
			halted_q   <= 1'b0;
			rem_q      <= 8'h0;
			pack_q     <= 32'h0;
			pack_cnt_q <= 2'd0;
			rd_v_s1    <= 1'b0;
			fifo_wr_q  <= 1'b0;
			fifo_rd_q  <= 1'b0;
			fifo_cnt_q <= 2'd0;
		end else begin
			st_q <= st_d;
			if (cfg_wr_en) limit_q <= cfg_wr_data;

			if (chunk_clr) begin
				ph_q       <= PH_TAG;
				lit_q      <= 8'h0;
				off_q      <= 16'h0;
				halted_q   <= 1'b0;
				wp_q       <= '0;
				produced_q <= 32'h0;
			end else begin
				if (acc) begin
					ph_q     <= ph_d;
					lit_q    <= lit_d;
					off_q    <= off_d;
					halted_q <= halt_d;
				end
				if (mem_we) begin
					wp_q       <= wp_inc;
					produced_q <= produced_q + 32'h1;
				end
			end
			if (acc && start_copy) rem_q <= len_c;
			else if (iss) rem_q <= rem_q - 8'h1;

			if (acc && start_copy) begin
				pack_q     <= 32'h0;
				pack_cnt_q <= 2'd0;
			end else if (adv) begin
				if (need_push) begin
					pack_q     <= 32'h0;
					pack_cnt_q <= 2'd0;
				end else begin
					pack_q     <= pack_next;
					pack_cnt_q <= pack_cnt_q + 2'd1;
				end
			end

			if (iss) rd_v_s1 <= 1'b1;
			else if (adv) rd_v_s1 <= 1'b0;

			if (push) fifo_wr_q <= !fifo_wr_q;
			if (pop) fifo_rd_q <= !fifo_rd_q;
			fifo_cnt_q <= fifo_cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

/* design/lztd_chk.sv */
module lztd_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [39:0] m_tdata,
	input logic        m_tlast,
	input logic [0:0]  m_tuser
);

	// hold a stalled result
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
		$stable(m_tuser))
		else $error("result changed while stalled");

	a_halt_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tlast)
		else $error("halt flag on a result that does not end the chunk");

	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[34:32] == 3'd0) |-> m_tlast)
		else $error("empty result that does not end the chunk");

	a_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[34:32] <= 3'd4) && (m_tdata[39:35] == 5'h0))
		else $error("byte count out of range");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && (m_tdata[34:32] != 3'd4) |-> m_tdata[31:24] == 8'h0)
		else $error("unused top byte not zero");

endmodule

bind lz77_token_decompressor lztd_chk u_lztd_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tlast  (m_tlast),
	.m_tuser  (m_tuser)
);

/* test/lz77_token_decompressor_check.sv */
`timescale 1ns / 1ps

module lz77_token_decompressor_check
	import lztd_pkg::*;
#(
	parameter int HISTORY_SIZE = HISTORY_SIZE_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [31:0] cfg_wr_data,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tlast,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [39:0] m_tdata,
	input  logic        m_tlast,
	input  logic [0:0]  m_tuser,
	output int          fail_count,
	output int          pending,
	output int          activity,
	output int          results_checked,
	output int          halted_chunks
);

	logic [7:0]  history_mem [HISTORY_SIZE];
	int unsigned wr_ptr;
	logic [31:0] produced;
	phase_t      phase;
	logic [7:0]  lit_left;
	logic [15:0] match_off;
	logic        halted_q;
	logic [31:0] byte_limit;

	res_t        expected_results[$];
	logic [7:0]  decoded_bytes[$];
	res_t        head;

	function automatic void store_byte(input logic [7:0] b);
		history_mem[wr_ptr] = b;
		wr_ptr = (wr_ptr + 1) % HISTORY_SIZE;
		produced = produced + 1;
		decoded_bytes.insert(decoded_bytes.size(), b);
	endfunction

	function automatic void compare_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			fail_count++;
		end
	endfunction

	function automatic void restart_chunk();
		wr_ptr = 0;
		produced = '0;
		phase = PH_TAG;
		lit_left = '0;
		match_off = '0;
		halted_q = 1'b0;
	endfunction

	task automatic expand_byte(input logic [7:0] b, input logic last);
		int unsigned n_res;
		int unsigned room;
		int unsigned len;
		int unsigned src;
		int unsigned cnt;
		res_t r;
		decoded_bytes.delete();
		if (!halted_q && produced < byte_limit) begin
			case (phase)
				PH_LIT: begin
					store_byte(b);
					if (lit_left > 0)
						lit_left--;
					if (lit_left == 0)
						phase = PH_TAG;
				end
				PH_OFF_LO: begin
					match_off = {8'h00, b};
					if (last)
						halted_q = 1'b1;
					else
						phase = PH_OFF_HI;
				end
				PH_OFF_HI: begin
					match_off[15:8] = b;
					if (last)
						halted_q = 1'b1;
					else
						phase = PH_LEN;
				end
				PH_LEN: begin
					phase = PH_TAG;
					if (match_off == 0 || match_off > produced || match_off > HISTORY_SIZE) begin
						halted_q = 1'b1;
					end else begin
						room = byte_limit - produced;
						len = b;
						if (len > room)
							len = room;
						src = (wr_ptr + HISTORY_SIZE - match_off) % HISTORY_SIZE;
						for (int k = 0; k < len; k++) begin
							store_byte(history_mem[src]);
							src = (src + 1) % HISTORY_SIZE;
						end
					end
				end
				default: begin
					if (b == MATCH_TAG) begin
						if (last)
							halted_q = 1'b1;
						else
							phase = PH_OFF_LO;
					end else if (b != 0) begin
						lit_left = b;
						phase = PH_LIT;
					end
				end
			endcase
		end
		n_res = (decoded_bytes.size() + 3) / 4;
		if (last && n_res == 0)
			n_res = 1;
		for (int i = 0; i < n_res; i++) begin
			cnt = (decoded_bytes.size() > 4 * i) ? decoded_bytes.size() - 4 * i : 0;
			if (cnt > 4)
				cnt = 4;
			r.data = '0;
			for (int j = 0; j < cnt; j++)
				r.data[8 * j +: 8] = decoded_bytes[4 * i + j];
			r.count = cnt[2:0];
			r.last = last && (i == n_res - 1);
			r.halted = halted_q;
			expected_results.insert(expected_results.size(), r);
		end
		if (last) begin
			if (halted_q)
				halted_chunks++;
			restart_chunk();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < HISTORY_SIZE; i++)
				history_mem[i] = '0;
			restart_chunk();
			byte_limit = '0;
			expected_results.delete();
			fail_count = 0;
			pending = 0;
			activity = 0;
			results_checked = 0;
			halted_chunks = 0;
		end else begin
			if (cfg_wr_en)
				byte_limit = cfg_wr_data;
			if (s_tvalid && s_tready) begin
				expand_byte(s_tdata, s_tlast);
				activity++;
			end
			if (m_tvalid && m_tready) begin
				activity++;
				results_checked++;
				if (expected_results.size() == 0) begin
					$error("unexpected result: data %0h count %0d last %0b halted %0b",
						m_tdata[31:0], m_tdata[34:32], m_tlast, m_tuser[0]);
					fail_count++;
				end else begin
					head = expected_results.pop_front();
					compare_field("out_data", head.data, m_tdata[31:0]);
					compare_field("out_count", head.count, m_tdata[34:32]);
					compare_field("out_last", head.last, m_tlast);
					compare_field("out_halted", head.halted, m_tuser[0]);
				end
			end
			pending = expected_results.size();
		end
	end

endmodule

/* test/lz77_token_decompressor_test.sv */
`timescale 1ns / 1ps

module lz77_token_decompressor_test
	import lztd_pkg::*;
();

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int PHASE_BYTES = 6;

	logic        clk;
	logic        arst_n;
	logic        cfg_wr_en;
	logic [31:0] cfg_wr_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [7:0]  s_tdata;
	logic        s_tlast;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;
	logic [0:0]  m_tuser;

	int          fail_count;
	int          pending;
	int          activity;
	int          results_checked;
	int          halted_chunks;

	logic        idle_on;
	int          ready_hold = 0;
	int          stuck_cycles = 0;
	int          seen_activity = 0;
	int          bytes_in;
	int          chunks_sent;
	logic [7:0]  chunk_q[$];
	logic [31:0] limits[6];

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	lz77_token_decompressor u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.s_tlast     (s_tlast),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.m_tuser     (m_tuser)
	);

	lz77_token_decompressor_check u_check (
		.clk             (clk),
		.arst_n          (arst_n),
		.cfg_wr_en       (cfg_wr_en),
		.cfg_wr_data     (cfg_wr_data),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tdata         (s_tdata),
		.s_tlast         (s_tlast),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.m_tlast         (m_tlast),
		.m_tuser         (m_tuser),
		.fail_count      (fail_count),
		.pending         (pending),
		.activity        (activity),
		.results_checked (results_checked),
		.halted_chunks   (halted_chunks)
	);

	always @(negedge clk) begin
		if (ready_hold > 0) begin
			m_tready <= 1'b0;
			ready_hold--;
		end else if (idle_on && $urandom_range(0, 4) == 0) begin
			m_tready <= 1'b0;
			ready_hold = $urandom_range(0, 3);
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && (s_tvalid || pending != 0) && activity == seen_activity)
			stuck_cycles++;
		else
			stuck_cycles = 0;
		seen_activity = activity;
		if (stuck_cycles >= WATCHDOG_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic send_byte(input logic [7:0] b, input logic last);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		s_tlast <= last;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		@(negedge clk);
		bytes_in++;
	endtask

	task automatic drive_chunk();
		foreach (chunk_q[i])
			send_byte(chunk_q[i], i == chunk_q.size() - 1);
		chunks_sent++;
	endtask

	task automatic write_limit(input logic [31:0] value);
		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (16) @(negedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic add_byte(input logic [7:0] b);
		chunk_q.insert(chunk_q.size(), b);
	endtask

	task automatic push_match(input int off, input int len);
		add_byte(MATCH_TAG);
		add_byte(off[7:0]);
		add_byte(off[15:8]);
		add_byte(len[7:0]);
	endtask

	// long chunks run past the history depth so the store wraps and the far-offset check fires
	task automatic make_chunk(input bit long_run);
		int est;
		int tokens;
		int kind;
		int n;
		int max_off;
		int off;
		chunk_q.delete();
		est = 0;
		tokens = long_run ? 64 : $urandom_range(1, 6);
		for (int t = 0; t < tokens; t++) begin
			if (long_run && est > 4200)
				break;
			if (est == 0)
				kind = 0;
			else if (long_run)
				kind = ($urandom_range(0, 5) == 0) ? 0 : 10;
			else
				kind = $urandom_range(0, 19);
			if (kind < 8) begin
				n = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 254) : $urandom_range(1, 12);
				add_byte(n[7:0]);
				repeat (n) add_byte(8'($urandom_range(0, 255)));
				est += n;
			end else if (kind < 16) begin
				max_off = (est > HISTORY_SIZE_DEF) ? HISTORY_SIZE_DEF : est;
				if ($urandom_range(0, 1) == 0)
					off = $urandom_range(1, (max_off > 8) ? 8 : max_off);
				else
					off = $urandom_range(1, max_off);
				if (long_run)
					n = $urandom_range(200, 255);
				else if ($urandom_range(0, 7) == 0)
					n = $urandom_range(21, 255);
				else
					n = $urandom_range(0, 20);
				push_match(off, n);
				est += n;
			end else if (kind < 17) begin
				add_byte(8'h00);
			end else if (kind < 19) begin
				off = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(est + 1, 65535);
				push_match(off, $urandom_range(0, 255));
			end else begin
				add_byte(8'($urandom_range(0, 255)));
			end
		end
		if (long_run) begin
			push_match(HISTORY_SIZE_DEF, $urandom_range(1, 255));
			push_match($urandom_range(HISTORY_SIZE_DEF + 1, 65535), $urandom_range(0, 255));
		end else if ($urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, chunk_q.size());
			while (chunk_q.size() > n)
				chunk_q.delete(chunk_q.size() - 1);
		end
	endtask

	initial begin
		int phase_start;
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tlast = 1'b0;
		idle_on = 1'b1;
		bytes_in = 0;
		chunks_sent = 0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		write_limit(32'hFFFF_FFFF);
		chunk_q = '{8'h03, 8'h00, 8'hFF, 8'h80,
			MATCH_TAG, 8'h01, 8'h00, 8'h05,
			MATCH_TAG, 8'h03, 8'h00, 8'h00,
			8'h00,
			MATCH_TAG, 8'h02, 8'h00, 8'h06};
		drive_chunk();
		chunk_q = '{8'h02, 8'hAA, 8'h55, MATCH_TAG, 8'h00, 8'h00, 8'h03, 8'h01};
		drive_chunk();

		limits[0] = 32'hFFFF_FFFF;
		limits[1] = 32'h0000_0000;
		limits[2] = 32'h0000_0001;
		limits[3] = $urandom_range(2, 60);
		limits[4] = $urandom;
		limits[5] = 32'hFFFF_FFFF;
		for (int p = 0; p < 6; p++) begin
			write_limit(limits[p]);
			if (p == 5)
				idle_on = 1'b0;
			if (p == 0) begin
				make_chunk(1'b1);
				drive_chunk();
			end
			phase_start = bytes_in;
			while (bytes_in - phase_start < PHASE_BYTES) begin
				make_chunk(1'b0);
				drive_chunk();
			end
		end

		s_tvalid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (40) @(negedge clk);
		$display("Sent %0d compressed bytes in %0d chunks across six output limits",
			bytes_in, chunks_sent);
		$display("Checked %0d results; %0d chunks stopped early", results_checked,
			halted_chunks);
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
